// ----- rtl/core/lmsf_pkg.sv -----
// Shared types and constants for the LMS adaptive FIR filter.
// No dependencies; every other module in rtl/core imports this package.
`default_nettype none

package lmsf_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned WEIGHT_W     = 32;
  localparam int unsigned STEP_W       = 16;
  localparam int unsigned MUL_W        = SAMPLE_W + WEIGHT_W;
  localparam int unsigned TAPS_DEFAULT = 16;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_STEP_SIZE     = 1'b0;
  localparam logic REG_OUTPUT_SELECT = 1'b1;

  localparam logic [STEP_W-1:0] STEP_SIZE_RESET = 16'd6554;

  // Operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MUL_MAC = 2'd0,
    MUL_GE  = 2'd1,
    MUL_UPD = 2'd2
  } mul_op_e;

  typedef struct packed {
    logic    shift_in;
    mul_op_e mul_op;
    logic    prod_en;
    logic    tap_rot;
    logic    w_rot;
    logic    w_upd;
    logic    acc_en;
    logic    est_en;
    logic    ge_en;
    logic    res_ld;
  } lmsf_cmd_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_size;
    logic              output_select;
  } lmsf_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/lmsf_ctrl.sv -----
// Sequencer of the LMS adaptive FIR: handshakes, tap counter, datapath commands.
// Depends on lmsf_pkg.
`default_nettype none

module lmsf_ctrl #(
  parameter int unsigned TAPS = lmsf_pkg::TAPS_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lmsf_pkg::lmsf_cmd_t     cmd_o
);
  import lmsf_pkg::*;

  localparam int unsigned CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS - 1);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_MAC       = 8'b0000_0010,
    ST_MAC_DRAIN = 8'b0000_0100,
    ST_EST       = 8'b0000_1000,
    ST_GE        = 8'b0001_0000,
    ST_UPD       = 8'b0010_0000,
    ST_UPD_DRAIN = 8'b0100_0000,
    ST_FINISH    = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             in_acc;
  logic             slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.mul_op = MUL_MAC;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.shift_in = 1'b1;
          cnt_d          = '0;
          state_d        = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd_o.mul_op  = MUL_MAC;
        cmd_o.prod_en = 1'b1;
        cmd_o.tap_rot = 1'b1;
        cmd_o.w_rot   = 1'b1;
        cmd_o.acc_en  = (cnt_q != '0);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_MAC_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MAC_DRAIN: begin
        cmd_o.acc_en = 1'b1;
        state_d      = ST_EST;
      end
      ST_EST: begin
        cmd_o.est_en = 1'b1;
        state_d      = ST_GE;
      end
      ST_GE: begin
        cmd_o.mul_op = MUL_GE;
        cmd_o.ge_en  = 1'b1;
        cnt_d        = '0;
        state_d      = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.mul_op  = MUL_UPD;
        cmd_o.prod_en = 1'b1;
        cmd_o.tap_rot = 1'b1;
        cmd_o.w_upd   = (cnt_q != '0);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_UPD_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_UPD_DRAIN: begin
        cmd_o.w_upd = 1'b1;
        state_d     = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd_o.res_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A new result only overwrites a slot that is empty or being taken
  a_res_ld_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_ld |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending result");

  // Block is busy on the cycle after a request is taken
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input ready right after accept");

  // Weight and tap rings stay aligned during the dot product
  a_mac_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.w_rot |-> (cmd_o.tap_rot && cmd_o.prod_en && !cmd_o.w_upd))
    else $error("rings out of step in dot product");

  // Last update write-back is followed by result hand-off
  a_drain_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD_DRAIN) |=> (state_q == ST_FINISH) && !in_ready_o)
    else $error("update drain not followed by finish");

endmodule

`default_nettype wire

// ----- rtl/core/lmsf_datapath.sv -----
// Datapath of the LMS adaptive FIR: tap and weight rings, shared multiplier,
// accumulator, rounding and saturation. Depends on lmsf_pkg.
`default_nettype none

module lmsf_datapath #(
  parameter int unsigned TAPS = lmsf_pkg::TAPS_DEFAULT
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire lmsf_pkg::lmsf_cmd_t                   cmd_i,
  input  wire lmsf_pkg::lmsf_cfg_t                   cfg_i,
  input  wire logic signed [lmsf_pkg::SAMPLE_W-1:0]  reference_sample_i,
  input  wire logic signed [lmsf_pkg::SAMPLE_W-1:0]  desired_sample_i,
  output logic signed [lmsf_pkg::SAMPLE_W-1:0]       result_sample_o
);
  import lmsf_pkg::*;

  localparam int unsigned ACC_W = MUL_W + $clog2(TAPS);

  localparam logic signed [ACC_W:0] EST_BIAS = 1 <<< 27;
  localparam logic signed [ACC_W:0] EST_HI   = 32767;
  localparam logic signed [ACC_W:0] EST_LO   = -32768;
  localparam logic signed [MUL_W-1:0] UPD_BIAS = 1 <<< 17;
  localparam logic signed [SAMPLE_W:0] ERR_HI  = 32767;
  localparam logic signed [SAMPLE_W:0] ERR_LO  = -32768;
  localparam logic signed [WEIGHT_W:0] W_HI    = (WEIGHT_W+1)'(33'sh0_7FFF_FFFF);
  localparam logic signed [WEIGHT_W:0] W_LO    = (WEIGHT_W+1)'(33'sh1_8000_0000);
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

  logic signed [SAMPLE_W-1:0] tap_q [TAPS];
  logic signed [WEIGHT_W-1:0] w_q   [TAPS];

  logic signed [SAMPLE_W-1:0] d_q;
  logic signed [MUL_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [SAMPLE_W-1:0] est_q;
  logic signed [SAMPLE_W-1:0] err_q;
  logic signed [WEIGHT_W-1:0] ge_q;
  logic signed [SAMPLE_W-1:0] result_q;

  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [WEIGHT_W-1:0] mul_b;
  logic signed [MUL_W-1:0]    mul_p;

  logic signed [ACC_W:0]      est_rnd;
  logic signed [SAMPLE_W-1:0] est_sat;
  logic signed [SAMPLE_W:0]   err_diff;
  logic signed [SAMPLE_W-1:0] err_sat;
  logic signed [MUL_W-1:0]    upd_rnd;
  logic signed [WEIGHT_W:0]   w_sum;
  logic signed [WEIGHT_W-1:0] w_new;

  // Shared multiplier operand select
  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_MAC: begin
        mul_a = tap_q[0];
        mul_b = w_q[0];
      end
      MUL_GE: begin
        mul_a = err_q;
        mul_b = WEIGHT_W'(cfg_i.step_size);
      end
      MUL_UPD: begin
        mul_a = tap_q[0];
        mul_b = ge_q;
      end
      default: begin
        mul_a = tap_q[0];
        mul_b = w_q[0];
      end
    endcase
  end

  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  // Estimate: round the sum of Q5.43 products to Q1.15, saturate; error: saturated difference
  always_comb begin
    est_rnd = ((ACC_W+1)'(acc_q) + EST_BIAS) >>> 28;
    if (est_rnd > EST_HI) begin
      est_sat = S_MAX;
    end else if (est_rnd < EST_LO) begin
      est_sat = S_MIN;
    end else begin
      est_sat = est_rnd[SAMPLE_W-1:0];
    end
    err_diff = (SAMPLE_W+1)'(d_q) - (SAMPLE_W+1)'(est_sat);
    if (err_diff > ERR_HI) begin
      err_sat = S_MAX;
    end else if (err_diff < ERR_LO) begin
      err_sat = S_MIN;
    end else begin
      err_sat = err_diff[SAMPLE_W-1:0];
    end
  end

  // Weight update: round Q2.46 step to Q4.28, add, saturate
  always_comb begin
    upd_rnd = (prod_q + UPD_BIAS) >>> 18;
    w_sum   = (WEIGHT_W+1)'(w_q[0]) + (WEIGHT_W+1)'(upd_rnd);
    if (w_sum > W_HI) begin
      w_new = W_HI[WEIGHT_W-1:0];
    end else if (w_sum < W_LO) begin
      w_new = W_LO[WEIGHT_W-1:0];
    end else begin
      w_new = w_sum[WEIGHT_W-1:0];
    end
  end

  // Tap ring: shift in on accept, rotate toward index 0 while working
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        tap_q[i] <= '0;
      end
    end else if (cmd_i.shift_in) begin
      tap_q[0] <= reference_sample_i;
      for (int i = 1; i < TAPS; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end else if (cmd_i.tap_rot) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        tap_q[i] <= tap_q[i+1];
      end
      tap_q[TAPS-1] <= tap_q[0];
    end
  end

  // Weight ring: plain rotate in dot product, rotate with write-back in update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        w_q[i] <= '0;
      end
    end else if (cmd_i.w_rot || cmd_i.w_upd) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[TAPS-1] <= cmd_i.w_upd ? w_new : w_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_in) begin
      d_q   <= desired_sample_i;
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.prod_en) begin
      prod_q <= mul_p;
    end
    if (cmd_i.est_en) begin
      est_q <= est_sat;
      err_q <= err_sat;
    end
    if (cmd_i.ge_en) begin
      ge_q <= mul_p[WEIGHT_W-1:0];
    end
    if (cmd_i.res_ld) begin
      result_q <= cfg_i.output_select ? err_q : est_q;
    end
  end

  assign result_sample_o = result_q;

endmodule

`default_nettype wire

// ----- rtl/core/lms_adaptive_fir.sv -----
// Top level of the LMS adaptive FIR filter: APB register file, sequencer
// and datapath. Depends on lmsf_pkg, lmsf_ctrl and lmsf_datapath.
//
//  channel | signals                                        | dir | accepted when
//  --------+------------------------------------------------+-----+------------------------
//  in      | in_valid_i/in_ready_o, reference/desired_sample | in  | in_valid_i & in_ready_o
//  out     | out_valid_o/out_ready_i, result_sample_o       | out | out_valid_o & out_ready_i
//  cfg     | psel penable pwrite paddr pwdata prdata pready | in  | psel & penable & pwrite
//
// A request is taken only in idle, after the previous one is through; the
// shared 16x32 multiplier does TAPS dot-product products, then one
// step*error product, then TAPS weight-update products.
// Result is registered; the next request is taken while it waits.
// Reset (rst_ni, async low) clears taps, weights and handshake state; no
// clearing pass. A stalled output holds the sequencer in its finish state.
`default_nettype none

module lms_adaptive_fir #(
  parameter int unsigned TAPS = lmsf_pkg::TAPS_DEFAULT
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // input request channel
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [lmsf_pkg::SAMPLE_W-1:0]  reference_sample_i,
  input  wire logic signed [lmsf_pkg::SAMPLE_W-1:0]  desired_sample_i,
  // result channel
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [lmsf_pkg::SAMPLE_W-1:0]       result_sample_o,
  // APB configuration port
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [lmsf_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire logic [lmsf_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [lmsf_pkg::APB_DATA_W-1:0]            prdata,
  output logic                                       pready
);
  import lmsf_pkg::*;

  logic [STEP_W-1:0] step_size_q, step_size_d;
  logic              output_select_q, output_select_d;
  logic              reg_idx;
  logic              cfg_wr;
  lmsf_cmd_t         cmd;
  lmsf_cfg_t         cfg;

  // No wait states on the APB side
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_comb begin
    step_size_d     = step_size_q;
    output_select_d = output_select_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_STEP_SIZE:     step_size_d     = pwdata[STEP_W-1:0];
        REG_OUTPUT_SELECT: output_select_d = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q     <= STEP_SIZE_RESET;
      output_select_q <= 1'b0;
    end else begin
      step_size_q     <= step_size_d;
      output_select_q <= output_select_d;
    end
  end

  // Readback: register value zero-extended to the bus
  always_comb begin
    unique case (reg_idx)
      REG_STEP_SIZE:     prdata = APB_DATA_W'(step_size_q);
      REG_OUTPUT_SELECT: prdata = APB_DATA_W'(output_select_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg.step_size     = step_size_q;
  assign cfg.output_select = output_select_q;

  lmsf_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  lmsf_datapath #(
    .TAPS (TAPS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_i              (cfg),
    .reference_sample_i (reference_sample_i),
    .desired_sample_i   (desired_sample_i),
    .result_sample_o    (result_sample_o)
  );

endmodule

`default_nettype wire

// ----- tb/lms_adaptive_fir_checker.sv -----
// Scoreboard for lms_adaptive_fir: follows APB register writes, predicts each
// result from the accepted sample pairs and compares results in arrival order.
// Depends on lmsf_pkg.
module lms_adaptive_fir_checker #(
  parameter int unsigned TAPS = lmsf_pkg::TAPS_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic signed [lmsf_pkg::SAMPLE_W-1:0] reference_sample_i,
  input  logic signed [lmsf_pkg::SAMPLE_W-1:0] desired_sample_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic signed [lmsf_pkg::SAMPLE_W-1:0] result_sample_i,
  input  logic                                 psel_i,
  input  logic                                 penable_i,
  input  logic                                 pwrite_i,
  input  logic                                 pready_i,
  input  logic [lmsf_pkg::APB_ADDR_W-1:0]      paddr_i,
  input  logic [lmsf_pkg::APB_DATA_W-1:0]      pwdata_i,
  output int                                   mismatch_count_o,
  output int                                   pending_o
);
  import lmsf_pkg::*;

  localparam longint EST_HALF = 64'sd1 <<< 27;
  localparam longint UPD_HALF = 64'sd1 <<< 17;
  localparam longint W_MAX    = 64'sd2147483647;
  localparam longint W_MIN    = -64'sd2147483648;
  localparam longint S_MAX    = 64'sd32767;
  localparam longint S_MIN    = -64'sd32768;

  // Model state: delay line (newest at 0), Q4.28 weights, register copies
  logic signed [SAMPLE_W-1:0] taps_q [TAPS];
  logic signed [WEIGHT_W-1:0] coef_q [TAPS];
  logic [STEP_W-1:0]          mu_q;
  logic                       sel_err_q;

  logic signed [SAMPLE_W-1:0] expected_q [$];
  int                         results_seen;

  initial mismatch_count_o = 0;
  initial pending_o = 0;
  initial results_seen = 0;

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the filter by one sample pair, returns the selected output.
  function automatic logic signed [SAMPLE_W-1:0] lms_filter_step(
      logic signed [SAMPLE_W-1:0] x, logic signed [SAMPLE_W-1:0] d);
    longint acc;
    longint est;
    longint err;
    longint prod;
    longint w;
    acc = 0;
    for (int i = TAPS - 1; i > 0; i--) taps_q[i] = taps_q[i-1];
    taps_q[0] = x;
    // estimate uses the weights from before this update
    for (int i = 0; i < TAPS; i++) acc += longint'(taps_q[i]) * longint'(coef_q[i]);
    est = clamp_to((acc + EST_HALF) >>> 28, S_MIN, S_MAX);
    err = clamp_to(longint'(d) - est, S_MIN, S_MAX);
    for (int i = 0; i < TAPS; i++) begin
      prod = longint'({48'd0, mu_q}) * longint'(taps_q[i]) * err;
      w = longint'(coef_q[i]) + ((prod + UPD_HALF) >>> 18);
      coef_q[i] = clamp_to(w, W_MIN, W_MAX);
    end
    return sel_err_q ? err : est;
  endfunction

  task automatic note_error(input string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) $display("[%0t] %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_ni) begin
      mu_q = STEP_SIZE_RESET;
      sel_err_q = 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        taps_q[i] = '0;
        coef_q[i] = '0;
      end
      expected_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_STEP_SIZE) mu_q = pwdata_i[STEP_W-1:0];
        else sel_err_q = pwdata_i[0];
      end
      // check outputs before queuing this edge's request
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          note_error($sformatf("result %0d arrived with nothing predicted (value %0d)",
                               results_seen, result_sample_i));
        end else begin
          want = expected_q.pop_front();
          if (result_sample_i !== want)
            note_error($sformatf("result %0d: expected %0d, got %0d",
                                 results_seen, want, result_sample_i));
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(lms_filter_step(reference_sample_i, desired_sample_i));
    end
    pending_o = expected_q.size();
  end

endmodule

// ----- tb/lms_adaptive_fir_tb.sv -----
// Top of the lms_adaptive_fir bench: clock, reset, APB register writes,
// sample stimulus and receiver back-pressure; checking is done by
// lms_adaptive_fir_checker. Depends on lmsf_pkg and the RTL.
module lms_adaptive_fir_tb;
  import lmsf_pkg::*;

  localparam int unsigned TAPS = TAPS_DEFAULT;
  // accept-to-accept spacing of the sequencer when the output does not stall
  localparam int ITEM_CYCLES = 2 * TAPS + 6;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 305;
  // no-progress limit: covers the long receiver hold plus a few requests
  localparam int STALL_LIMIT = 4000;
  // receiver hold-off: starts after this many results, lasts this long
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 400;

  // flavors of random sample streams
  typedef enum int {
    SIG_NOISE,   // independent full-range samples
    SIG_PLANT,   // desired comes from a fixed 3-tap system, so the filter converges
    SIG_QUIET,   // small amplitudes, exercises rounding near zero
    SIG_EXTREME  // rails, zero and -1 mixed with random
  } sig_kind_e;

  logic                       clk_i              = 1'b0;
  logic                       rst_ni             = 1'b0;
  logic                       in_valid_i         = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] reference_sample_i = '0;
  logic signed [SAMPLE_W-1:0] desired_sample_i   = '0;
  logic                       out_valid_o;
  logic                       out_ready_i        = 1'b0;
  logic signed [SAMPLE_W-1:0] result_sample_o;
  logic                       psel               = 1'b0;
  logic                       penable            = 1'b0;
  logic                       pwrite             = 1'b0;
  logic [APB_ADDR_W-1:0]      paddr              = '0;
  logic [APB_DATA_W-1:0]      pwdata             = '0;
  logic [APB_DATA_W-1:0]      prdata;
  logic                       pready;

  int mismatch_count;
  int pending;

  // idle percentages per side, changed by the stimulus between phases
  int tx_idle_pct = 35;
  int rx_idle_pct = 73;

  // last two reference samples, for the plant model of SIG_PLANT
  logic signed [SAMPLE_W-1:0] hist1 = '0;
  logic signed [SAMPLE_W-1:0] hist2 = '0;

  always #5 clk_i = ~clk_i;

  lms_adaptive_fir #(.TAPS(TAPS)) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .reference_sample_i (reference_sample_i),
    .desired_sample_i   (desired_sample_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_sample_o    (result_sample_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  lms_adaptive_fir_checker #(.TAPS(TAPS)) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .reference_sample_i (reference_sample_i),
    .desired_sample_i   (desired_sample_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_sample_i    (result_sample_o),
    .psel_i             (psel),
    .penable_i          (penable),
    .pwrite_i           (pwrite),
    .pready_i           (pready),
    .paddr_i            (paddr),
    .pwdata_i           (pwdata),
    .mismatch_count_o   (mismatch_count),
    .pending_o          (pending)
  );

  // APB write: setup cycle, then access until pready; one spare cycle after
  // so a following write never re-raises psel in the same time step.
  task automatic write_reg(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one request, with random idle cycles ahead of it, and returns at
  // the edge where it is accepted. Valid stays high across back-to-back
  // requests, so it is never dropped and raised in the same step.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] x,
                             input logic signed [SAMPLE_W-1:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    reference_sample_i <= x;
    desired_sample_i   <= d;
    hist2 = hist1;
    hist1 = x;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drops valid, waits until every predicted result has come back, then a
  // few more cycles so the sequencer is back in idle before a register write.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_extreme();
    case ($urandom_range(4))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return $urandom_range(16'hFFFF);
    endcase
  endfunction

  // Random requests in segments of 32 that share one stream flavor.
  task automatic send_random(input int count);
    sig_kind_e                  kind;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] d;
    kind = SIG_NOISE;
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) kind = sig_kind_e'($urandom_range(3));
      case (kind)
        SIG_NOISE: begin
          x = $urandom_range(16'hFFFF);
          d = $urandom_range(16'hFFFF);
        end
        SIG_PLANT: begin
          // 0.5*x[n] + 0.25*x[n-1] - 0.125*x[n-2]; stays inside 16 bits
          x = $urandom_range(16'hFFFF);
          d = (x >>> 1) + (hist1 >>> 2) - (hist2 >>> 3);
        end
        SIG_QUIET: begin
          x = int'($urandom_range(511)) - 256;
          d = int'($urandom_range(511)) - 256;
        end
        default: begin
          x = pick_extreme();
          d = pick_extreme();
        end
      endcase
      push_sample(x, d);
    end
  endtask

  // Receiver: random ready per the current idle rate, plus one long hold-off
  // after HOLD_AT results so the result register fills and in_ready drops
  // while the sender keeps offering.
  int  drained   = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) drained++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && drained >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: any handshake or register access counts as progress.
  int stall_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("lms_adaptive_fir: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [STEP_W-1:0] step;
    logic              sel;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: largest gain, error output, junk above the register widths.
    // Repeated full-scale pairs drive the weights into saturation.
    write_reg(REG_STEP_SIZE, 32'hFFFF_FFFF);
    write_reg(REG_OUTPUT_SELECT, 32'h8000_0001);
    push_sample(16'sh0000, 16'sh0000);
    push_sample(16'sh7FFF, 16'sh7FFF);
    push_sample(16'sh7FFF, 16'sh7FFF);
    push_sample(16'sh8000, 16'sh8000);
    push_sample(16'sh8000, 16'sh7FFF);
    push_sample(16'sh7FFF, 16'sh8000);
    push_sample(16'sh0001, -16'sd1);
    push_sample(-16'sd1, 16'sh0001);
    push_sample(16'sh5555, 16'shAAAA);
    push_sample(16'shAAAA, 16'sh5555);
    repeat (6) push_sample(16'sh7FFF, 16'sh8000);
    settle();

    // Estimate output with saturated weights: estimate clips at both rails
    write_reg(REG_OUTPUT_SELECT, 32'hFFFF_FFFE);
    repeat (5) push_sample(16'sh7FFF, 16'sh7FFF);
    push_sample(16'sh8000, 16'sh0000);
    push_sample(16'sh8000, 16'sh0000);
    push_sample(16'sh0000, 16'sh0000);

    // Random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       begin step = STEP_SIZE_RESET;           sel = 1'b0;                end
        1:       begin step = 16'hFFFF;                  sel = 1'b1;                end
        2:       begin step = 16'h0000;                  sel = 1'b0;                end
        3:       begin step = $urandom_range(16'hFFFF);  sel = 1'b1;                end
        4:       begin step = $urandom_range(2000, 300); sel = 1'b0;                end
        default: begin step = $urandom_range(16'hFFFF);  sel = $urandom_range(1);  end
      endcase
      // sender/receiver idle rates swap after two phases, vanish after four
      if (p == 2) begin
        tx_idle_pct = 73;
        rx_idle_pct = 35;
      end else if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_reg(REG_STEP_SIZE, ($urandom & 32'hFFFF_0000) | step);
      write_reg(REG_OUTPUT_SELECT, ($urandom & 32'hFFFF_FFFE) | sel);
      send_random(PHASE_ITEMS);
    end

    settle();
    repeat (ITEM_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("lms_adaptive_fir: match");
    end else begin
      $display("lms_adaptive_fir: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/lmsf_pkg.sv
rtl/core/lmsf_ctrl.sv
rtl/core/lmsf_datapath.sv
rtl/core/lms_adaptive_fir.sv
tb/lms_adaptive_fir_checker.sv
tb/lms_adaptive_fir_tb.sv
